>>> rtl/hamming_sec_decoder_macros.svh
// Assertion macros shared by the Hamming SEC decoder RTL.
// Included by files that carry concurrent assertions; depends on nothing.
`ifndef HAMMING_SEC_DECODER_MACROS_SVH
`define HAMMING_SEC_DECODER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define HSD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define HSD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/hsd_pkg.sv
// Shared widths, control types and bit-mapping functions of the Hamming SEC decoder.
// Used by the interfaces, the pipeline stages and the top level; depends on nothing.
`default_nettype none

package hsd_pkg;

	localparam int CODE_W        = 63;
	localparam int LEN_W         = 6;
	localparam int SYN_W         = 6;
	localparam int DATA_W        = 57;
	localparam int MAX_CODE_BITS_DEF = 63;
	localparam logic [LEN_W-1:0] LEN_RESET = 6'd7;

	// Control that travels with each item through the pipeline.
	typedef struct packed {
		logic             valid;
		logic [LEN_W-1:0] len;
	} hsd_ctrl_t;

	// Positions k (1-based) whose index has bit bit_idx set; position k is bit k-1.
	function automatic logic [CODE_W-1:0] parity_mask(input int unsigned bit_idx);
		logic [CODE_W-1:0] m;
		m = '0;
		for (int k = 1; k <= CODE_W; k++) begin
			m[k-1] = ((k >> bit_idx) & 1) != 0;
		end
		return m;
	endfunction

	// Packs the positions that are not powers of two, lowest position first.
	function automatic logic [DATA_W-1:0] pack_data(input logic [CODE_W-1:0] w);
		logic [DATA_W-1:0] d;
		int                n;
		d = '0;
		n = 0;
		for (int k = 1; k <= CODE_W; k++) begin
			if ((k & (k - 1)) != 0) begin
				d[n] = w[k-1];
				n++;
			end
		end
		return d;
	endfunction

endpackage

`default_nettype wire

>>> rtl/hsd_ifs.sv
// Valid/ready channel interfaces of the Hamming SEC decoder: received words in, results out.
// Depends on hsd_pkg for the payload widths.
`default_nettype none

interface hsd_word_if import hsd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CODE_W-1:0] received_word;

	modport source (output valid, output received_word, input ready);
	modport sink (input valid, input received_word, output ready);
endinterface

interface hsd_result_if import hsd_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [SYN_W-1:0]  syndrome;
	logic              error_found;
	logic              uncorrectable;
	logic [CODE_W-1:0] corrected_word;
	logic [DATA_W-1:0] data_bits;

	modport source (output valid, output syndrome, output error_found,
		output uncorrectable, output corrected_word, output data_bits, input ready);
	modport sink (input valid, input syndrome, input error_found,
		input uncorrectable, input corrected_word, input data_bits, output ready);
endinterface

`default_nettype wire

>>> rtl/hamming_sec_decoder.sv
// Hamming single-error-correcting decoder, three register stages: mask, syndrome, correct.
// A received word passes through the mask, syndrome and correct registers before its result is offered.
// Throughput: one word per cycle; a stalled result stage holds the pipeline back in place.
// Reset (arst_n low, asynchronous) empties the pipeline and sets code_length to 7.
// Depends on hsd_pkg, the channel interfaces and the three stage modules.
`default_nettype none
`include "hamming_sec_decoder_macros.svh"

module hamming_sec_decoder import hsd_pkg::*; #(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             cfg_wr_en,
	input wire logic [LEN_W-1:0] cfg_wr_data,
	hsd_word_if.sink             word_chan,
	hsd_result_if.source         result_chan
);

	logic [LEN_W-1:0]         code_length_q;
	logic                     en_s1;
	logic                     en_s2;
	logic                     en_s3;
	hsd_ctrl_t                ctrl_s1;
	hsd_ctrl_t                ctrl_s2;
	hsd_ctrl_t                ctrl_s3;
	logic [MAX_CODE_BITS-1:0] word_s1;
	logic [MAX_CODE_BITS-1:0] word_s2;
	logic [SYN_W-1:0]         syn_s2;
	logic [SYN_W-1:0]         syndrome_s3;
	logic                     error_found_s3;
	logic                     uncorrectable_s3;
	logic [CODE_W-1:0]        corrected_s3;
	logic [DATA_W-1:0]        data_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_length_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			code_length_q <= cfg_wr_data;
		end
	end

	// A stage loads when it is empty or when the stage after it loads this cycle.
	assign en_s3 = !ctrl_s3.valid || result_chan.ready;
	assign en_s2 = !ctrl_s2.valid || en_s3;
	assign en_s1 = !ctrl_s1.valid || en_s2;

	assign word_chan.ready = en_s1;

	hsd_mask_stage #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_mask (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en_s1),
		.in_valid     (word_chan.valid),
		.received_word(word_chan.received_word),
		.code_length  (code_length_q),
		.ctrl_s1      (ctrl_s1),
		.word_s1      (word_s1)
	);

	hsd_syn_stage #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_syn (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en_s2),
		.ctrl_s1(ctrl_s1),
		.word_s1(word_s1),
		.ctrl_s2(ctrl_s2),
		.word_s2(word_s2),
		.syn_s2 (syn_s2)
	);

	hsd_fix_stage #(
		.MAX_CODE_BITS(MAX_CODE_BITS)
	) u_fix (
		.clk             (clk),
		.arst_n          (arst_n),
		.en              (en_s3),
		.ctrl_s2         (ctrl_s2),
		.word_s2         (word_s2),
		.syn_s2          (syn_s2),
		.ctrl_s3         (ctrl_s3),
		.syndrome_s3     (syndrome_s3),
		.error_found_s3  (error_found_s3),
		.uncorrectable_s3(uncorrectable_s3),
		.corrected_s3    (corrected_s3),
		.data_s3         (data_s3)
	);

	assign result_chan.valid          = ctrl_s3.valid;
	assign result_chan.syndrome       = syndrome_s3;
	assign result_chan.error_found    = error_found_s3;
	assign result_chan.uncorrectable  = uncorrectable_s3;
	assign result_chan.corrected_word = corrected_s3;
	assign result_chan.data_bits      = data_s3;

	`HSD_ASSERT_SAME(a_uncorr_is_error, clk, arst_n, ctrl_s3.valid && uncorrectable_s3, error_found_s3, "uncorrectable result without error flag")
	`HSD_ASSERT_SAME(a_upper_bits_zero, clk, arst_n, ctrl_s3.valid, (corrected_s3 >> ctrl_s3.len) == '0, "corrected word has bits above the code length")
	`HSD_ASSERT_NEXT(a_s2_held_on_stall, clk, arst_n, ctrl_s3.valid && !result_chan.ready && ctrl_s2.valid, ctrl_s2.valid, "item in syndrome stage lost during stall")
	`HSD_ASSERT_NEXT(a_s1_held_on_stall, clk, arst_n, !en_s2 && ctrl_s1.valid, ctrl_s1.valid && $stable(word_s1), "item in mask stage changed during stall")

endmodule

`default_nettype wire

>>> rtl/hsd_mask_stage.sv
// First pipeline stage: clamps the code length and clears positions above it.
// Depends on hsd_pkg.
`default_nettype none

module hsd_mask_stage import hsd_pkg::*; #(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire logic                     in_valid,
	input  wire logic [CODE_W-1:0]        received_word,
	input  wire logic [LEN_W-1:0]         code_length,
	output hsd_ctrl_t                     ctrl_s1,
	output logic      [MAX_CODE_BITS-1:0] word_s1
);

	localparam logic [LEN_W-1:0] MaxLen = LEN_W'(MAX_CODE_BITS);

	logic [LEN_W-1:0]         len_eff;
	logic [MAX_CODE_BITS-1:0] masked;

	always_comb begin
		len_eff = (code_length > MaxLen) ? MaxLen : code_length;
		for (int i = 0; i < MAX_CODE_BITS; i++) begin
			masked[i] = received_word[i] & (LEN_W'(i) < len_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s1 <= '0;
		end else if (en) begin
			ctrl_s1.valid <= in_valid;
			ctrl_s1.len   <= len_eff;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s1 <= masked;
		end
	end

endmodule

`default_nettype wire

>>> rtl/hsd_syn_stage.sv
// Second pipeline stage: parity trees that form the syndrome of the masked word.
// Depends on hsd_pkg.
`default_nettype none

module hsd_syn_stage import hsd_pkg::*; #(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire hsd_ctrl_t                ctrl_s1,
	input  wire logic [MAX_CODE_BITS-1:0] word_s1,
	output hsd_ctrl_t                     ctrl_s2,
	output logic      [MAX_CODE_BITS-1:0] word_s2,
	output logic      [SYN_W-1:0]         syn_s2
);

	logic [SYN_W-1:0] syn_d;

	// Positions above the length are already zero, so each check covers the full word;
	// a set bit of the syndrome is the sum term of that parity position.
	always_comb begin
		for (int b = 0; b < SYN_W; b++) begin
			syn_d[b] = ^(word_s1 & MAX_CODE_BITS'(parity_mask(b)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s2 <= '0;
		end else if (en) begin
			ctrl_s2 <= ctrl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			word_s2 <= word_s1;
			syn_s2  <= syn_d;
		end
	end

endmodule

`default_nettype wire

>>> rtl/hsd_fix_stage.sv
// Third pipeline stage: flags, single-bit correction and data-bit extraction.
// Depends on hsd_pkg; its registers drive the result channel.
`default_nettype none

module hsd_fix_stage import hsd_pkg::*; #(
	parameter int MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     en,
	input  wire hsd_ctrl_t                ctrl_s2,
	input  wire logic [MAX_CODE_BITS-1:0] word_s2,
	input  wire logic [SYN_W-1:0]         syn_s2,
	output hsd_ctrl_t                     ctrl_s3,
	output logic      [SYN_W-1:0]         syndrome_s3,
	output logic                          error_found_s3,
	output logic                          uncorrectable_s3,
	output logic      [CODE_W-1:0]        corrected_s3,
	output logic      [DATA_W-1:0]        data_s3
);

	logic                     uncorr;
	logic                     flip;
	logic [MAX_CODE_BITS-1:0] fixed;

	// A syndrome that names a position past the length is reported, not applied.
	always_comb begin
		uncorr = syn_s2 > ctrl_s2.len;
		flip   = (syn_s2 != '0) && !uncorr;
		for (int i = 0; i < MAX_CODE_BITS; i++) begin
			fixed[i] = word_s2[i] ^ (flip && (syn_s2 == LEN_W'(i + 1)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_s3 <= '0;
		end else if (en) begin
			ctrl_s3 <= ctrl_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			syndrome_s3      <= syn_s2;
			error_found_s3   <= syn_s2 != '0;
			uncorrectable_s3 <= uncorr;
			corrected_s3     <= CODE_W'(fixed);
			data_s3          <= pack_data(CODE_W'(fixed));
		end
	end

endmodule

`default_nettype wire
